// File: hdl/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

	localparam int MEM_ADDR_BITS = 12;
	localparam int LANE_BITS     = 2;
	localparam int NLANES        = 1 << LANE_BITS;
	localparam int ROW_BITS      = MEM_ADDR_BITS - LANE_BITS;
	localparam longint ROWS      = 64'd1 << ROW_BITS;

	localparam logic [7:0] OPC_MOV     = 8'hF0;
	localparam logic [7:0] T_IMM       = 8'h00;
	localparam logic [7:0] T_ABS_B     = 8'h01;
	localparam logic [7:0] T_ABS_W     = 8'h02;
	localparam logic [7:0] T_ABS_D     = 8'h03;
	localparam logic [7:0] T_REG_LO    = 8'h04;
	localparam logic [7:0] T_REG_HI    = 8'h20;
	localparam logic [7:0] T_ADD_B     = 8'h21;
	localparam logic [7:0] T_ADD_W     = 8'h22;
	localparam logic [7:0] T_SUB_B     = 8'h24;
	localparam logic [7:0] T_SUB_W     = 8'h25;
	localparam logic [7:0] T_MAX       = 8'h26;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_OPC  = 2'd1;
	localparam logic [1:0] ST_BAD_OPND = 2'd2;
	localparam logic [1:0] ST_NO_MATCH = 2'd3;

	localparam logic [1:0] SZ_BYTE     = 2'd0;
	localparam logic [1:0] SZ_WORD     = 2'd1;
	localparam logic [1:0] SZ_DWORD    = 2'd2;

	localparam logic [2:0] K_NONE      = 3'd0;
	localparam logic [2:0] K_REG       = 3'd1;
	localparam logic [2:0] K_IMM       = 3'd2;
	localparam logic [2:0] K_LOAD      = 3'd3;
	localparam logic [2:0] K_STORE     = 3'd4;

	localparam logic [1:0] AM_ABS      = 2'd0;
	localparam logic [1:0] AM_ADD      = 2'd1;
	localparam logic [1:0] AM_SUB      = 2'd2;

	localparam logic [31:0] WRAP_TOP   = 32'hFFFFFFFE;

	typedef struct packed {
		logic                     rd;
		logic                     wr;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [1:0]               size;
		logic [31:0]              wdata;
	} dmem_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        reg_written;
		logic [7:0]  reg_index;
		logic [63:0] reg_value;
		logic        mem_written;
		logic [31:0] mem_address;
		logic [1:0]  mem_size;
		logic [31:0] mem_data;
	} result_t;

	function automatic logic is_reg(input logic [7:0] t);
		return (t >= T_REG_LO) && (t <= T_REG_HI);
	endfunction

	function automatic logic [1:0] size_code(input logic [7:0] t);
		logic [1:0] sz;
		if (t == T_ABS_B || t == T_ADD_B || t == T_SUB_B) begin
			sz = SZ_BYTE;
		end else if (t == T_ABS_W || t == T_ADD_W || t == T_SUB_W) begin
			sz = SZ_WORD;
		end else begin
			sz = SZ_DWORD;
		end
		return sz;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mie_dmem.sv
`timescale 1ns / 1ps
`default_nettype none

module mie_dmem (
	input  wire              clk,
	input  wire              arst_n,
	input  mie_pkg::dmem_req_t req,
	output logic             busy,
	output logic [31:0]      rdata
);
	import mie_pkg::*;

	logic                 clr_q;
	logic [ROW_BITS-1:0]  clr_row_q;
	logic [LANE_BITS-1:0] lane0;
	logic [ROW_BITS-1:0]  row0;
	logic [2:0]           nbytes;
	logic [LANE_BITS-1:0] lane0_q;
	logic [2:0]           nbytes_q;
	logic [7:0]           lane_rd [NLANES];

	assign busy   = clr_q;
	assign lane0  = req.addr[LANE_BITS-1:0];
	assign row0   = req.addr[MEM_ADDR_BITS-1:LANE_BITS];
	assign nbytes = 3'd1 << req.size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			clr_row_q <= clr_row_q + ROW_BITS'(1);
			if (clr_row_q == '1) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			lane0_q  <= lane0;
			nbytes_q <= nbytes;
		end
	end

	for (genvar j = 0; j < NLANES; j++) begin : g_lane
		logic [7:0]           mem [ROWS];
		logic [7:0]           q;
		logic [LANE_BITS-1:0] k;
		logic [ROW_BITS-1:0]  row;
		logic [7:0]           wbyte;
		logic                 we;
		logic [ROW_BITS-1:0]  wrow;
		logic [31:0]          wsh;

		assign k     = LANE_BITS'(j) - lane0;
		assign row   = (LANE_BITS'(j) < lane0) ? row0 + ROW_BITS'(1) : row0;
		assign wsh   = req.wdata >> {k, 3'b000};
		assign wbyte = clr_q ? 8'h00 : wsh[7:0];
		assign we    = clr_q | (req.wr & ({1'b0, k} < nbytes));
		assign wrow  = clr_q ? clr_row_q : row;

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wrow] <= wbyte;
			end
			if (req.rd) begin
				q <= mem[row];
			end
		end

		assign lane_rd[j] = q;
	end

	always_comb begin
		logic [LANE_BITS-1:0] ln;
		rdata = '0;
		for (int k = 0; k < NLANES; k++) begin
			ln = lane0_q + LANE_BITS'(k);
			if (3'(k) < nbytes_q) begin
				rdata[8*k +: 8] = lane_rd[ln];
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/move_instruction_executor_top.sv
// Path: a result is registered through stage 1, stage 2 and the output register, all held on a stall.
// Throughput: one instruction per cycle when neither the output stalls nor memory clears;
// stages are register read, memory access, register write-back, each a synchronous
// memory access, with forwarding. Reset: arst_n clears control state; the data memory
// is then cleared one row per cycle, all 1024 rows, during which s_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module move_instruction_executor_top (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [63:0]  s_tdata,  // instruction_word[63:0]
	output logic         m_tvalid,
	input  wire          m_tready,
	// status[1:0], reg_written[2], reg_index[10:3], reg_value[74:11], mem_written[75],
	// mem_address[107:76], mem_size[109:108], mem_data[141:110], zero[143:142]
	output logic [143:0] m_tdata
);
	import mie_pkg::*;

	logic adv, acc, busy;

	logic [63:0]  rf_mem [256];
	logic [255:0] rf_vld_q;

	logic [7:0]  dt, st_r, st_m, mt, ia, ib;
	logic [2:0]  kind;
	logic [1:0]  status, amode;

	logic        v_s1;
	logic [2:0]  kind_s1;
	logic [1:0]  status_s1, amode_s1, size_s1;
	logic [7:0]  didx_s1, ia_s1, ib_s1;
	logic [31:0] abs_s1;
	logic [23:0] off_s1;
	logic [63:0] rda_s1, rdb_s1;
	logic        va_s1, vb_s1;

	logic [63:0] base, src, val;
	logic [31:0] addr, off32, vlow, valt;
	logic        borrow, wrap;
	dmem_req_t   dreq;
	logic [31:0] ld_data;

	logic        v_s2;
	logic [2:0]  kind_s2;
	logic [1:0]  status_s2, size_s2;
	logic [7:0]  didx_s2;
	logic [63:0] val_s2, src_s2;
	logic [31:0] addr_s2;

	logic        rwe;
	logic [63:0] rv;
	result_t     res, res_q;
	logic        outv_q;

	logic        wb_vld_q;
	logic [7:0]  wb_idx_q;
	logic [63:0] wb_val_q;

	function automatic logic [63:0] fwd(
		input logic [7:0]  idx,
		input logic [63:0] ram,
		input logic        vld,
		input logic        s2_hit,
		input logic [7:0]  s2_idx,
		input logic [63:0] s2_val,
		input logic        wb_hit,
		input logic [7:0]  wb_idx,
		input logic [63:0] wb_val
	);
		logic [63:0] r;
		if (s2_hit && s2_idx == idx) begin
			r = s2_val;
		end else if (wb_hit && wb_idx == idx) begin
			r = wb_val;
		end else begin
			r = vld ? ram : 64'd0;
		end
		return r;
	endfunction

	assign adv      = !outv_q || m_tready;
	assign s_tready = adv && !busy;
	assign acc      = s_tvalid && s_tready;

	// decode
	assign dt   = s_tdata[55:48];
	assign st_r = s_tdata[47:40];
	assign st_m = s_tdata[15:8];
	assign ia   = is_reg(dt) ? s_tdata[39:32] : s_tdata[47:40];
	assign ib   = is_reg(dt) ? st_r : st_m;

	always_comb begin
		kind   = K_NONE;
		status = ST_OK;
		mt     = dt;
		if (s_tdata[63:56] != OPC_MOV) begin
			status = ST_BAD_OPC;
		end else if (dt > T_MAX) begin
			status = ST_BAD_OPND;
		end else if (is_reg(dt)) begin
			if (is_reg(st_r)) begin
				kind = K_REG;
			end else if (st_r == T_IMM) begin
				kind = K_IMM;
			end else if (st_r <= T_MAX) begin
				kind = K_LOAD;
				mt   = st_r;
			end else begin
				status = ST_NO_MATCH;
			end
		end else if (!is_reg(st_m) || dt == T_IMM) begin
			status = ST_BAD_OPND;
		end else begin
			kind = K_STORE;
		end
		if (mt <= T_ABS_D) begin
			amode = AM_ABS;
		end else if (mt < T_SUB_B) begin
			amode = AM_ADD;
		end else begin
			amode = AM_SUB;
		end
	end

	// register file read
	always_ff @(posedge clk) begin
		if (acc) begin
			rda_s1 <= rf_mem[ia];
			rdb_s1 <= rf_mem[ib];
			va_s1  <= rf_vld_q[ia];
			vb_s1  <= rf_vld_q[ib];
			kind_s1   <= kind;
			status_s1 <= status;
			amode_s1  <= amode;
			size_s1   <= size_code(mt);
			didx_s1   <= dt;
			ia_s1     <= ia;
			ib_s1     <= ib;
			abs_s1    <= is_reg(dt) ? s_tdata[39:8] : s_tdata[47:16];
			off_s1    <= is_reg(dt) ? s_tdata[31:8] : s_tdata[39:16];
		end
		if (adv && rwe) begin
			rf_mem[didx_s2] <= rv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			wb_vld_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			outv_q   <= 1'b0;
		end else if (adv) begin
			v_s1   <= acc;
			v_s2   <= v_s1;
			outv_q <= v_s2;
			if (rwe) begin
				rf_vld_q[didx_s2] <= 1'b1;
				wb_vld_q          <= 1'b1;
			end
		end
	end

	// address and memory access
	always_comb begin
		base = fwd(ia_s1, rda_s1, va_s1, rwe, didx_s2, rv, wb_vld_q, wb_idx_q, wb_val_q);
		src  = fwd(ib_s1, rdb_s1, vb_s1, rwe, didx_s2, rv, wb_vld_q, wb_idx_q, wb_val_q);
		off32  = {8'd0, off_s1};
		borrow = base[31:0] < off32;
		vlow   = base[31:0] - off32;
		valt   = WRAP_TOP - base[31:0] + off32;
		wrap   = base[63:32] != {31'd0, borrow};
		unique case (amode_s1)
			AM_ADD:  addr = base[31:0] + off32;
			AM_SUB:  addr = wrap ? valt : vlow;
			default: addr = abs_s1;
		endcase
		unique case (kind_s1)
			K_REG:   val = src;
			K_IMM:   val = {32'd0, abs_s1};
			default: val = 64'd0;
		endcase
		dreq.rd    = adv && v_s1 && kind_s1 == K_LOAD;
		dreq.wr    = adv && v_s1 && kind_s1 == K_STORE;
		dreq.addr  = addr[MEM_ADDR_BITS-1:0];
		dreq.size  = size_s1;
		dreq.wdata = src[31:0];
	end

	mie_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.busy   (busy),
		.rdata  (ld_data)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2   <= kind_s1;
			status_s2 <= status_s1;
			size_s2   <= size_s1;
			didx_s2   <= didx_s1;
			val_s2    <= val;
			src_s2    <= src;
			addr_s2   <= addr;
			res_q     <= res;
			if (rwe) begin
				wb_idx_q <= didx_s2;
				wb_val_q <= rv;
			end
		end
	end

	// write-back and result
	always_comb begin
		rwe = v_s2 && (kind_s2 == K_REG || kind_s2 == K_IMM || kind_s2 == K_LOAD);
		rv  = (kind_s2 == K_LOAD) ? {32'd0, ld_data} : val_s2;
		res = '0;
		res.status = status_s2;
		if (rwe) begin
			res.reg_written = 1'b1;
			res.reg_index   = didx_s2;
			res.reg_value   = rv;
		end
		if (kind_s2 == K_STORE) begin
			res.mem_written = 1'b1;
			res.mem_address = addr_s2;
			res.mem_size    = size_s2;
			unique case (size_s2)
				SZ_BYTE:  res.mem_data = {24'd0, src_s2[7:0]};
				SZ_WORD:  res.mem_data = {16'd0, src_s2[15:0]};
				default:  res.mem_data = src_s2[31:0];
			endcase
		end
	end

	assign m_tvalid = outv_q;
	assign m_tdata  = {2'b00, res_q.mem_data, res_q.mem_size, res_q.mem_address,
		res_q.mem_written, res_q.reg_value, res_q.reg_index, res_q.reg_written,
		res_q.status};

`ifndef ASSERT_OFF
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("transfer accepted during memory clear");
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.status != ST_OK) |-> (!res_q.reg_written && !res_q.mem_written))
		else $error("write reported with failing status");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.reg_written && res_q.mem_written))
		else $error("register and memory both written");
	a_wb_range: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rwe) |-> (didx_s2 >= T_REG_LO && didx_s2 <= T_REG_HI))
		else $error("write-back to a register outside the file range");
`endif

endmodule

`default_nettype wire
